### src/msq_pkg.sv
// Package for the marching squares cell emitter: widths, point codes, case tables
package msq_pkg;

  localparam int IndexBits    = 10;
  localparam int SampleBits   = 16;
  localparam int FractionBits = 12;
  localparam int PosBits      = IndexBits + FractionBits + 1;
  // numerator and divisor width for centre lines (4*sample terms)
  localparam int DivBits      = SampleBits + 3;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = 2;

  typedef enum logic [2:0] {
    PT_S   = 3'd0,
    PT_E   = 3'd1,
    PT_N   = 3'd2,
    PT_W   = 3'd3,
    PT_CSW = 3'd4,
    PT_CSE = 3'd5,
    PT_CNE = 3'd6,
    PT_CNW = 3'd7
  } pt_code_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_OUT  = 2'd2
  } bk_state_t;

  typedef struct packed {
    logic [2:0] len0;
    logic [2:0] len1;
    logic [5:0][2:0] pts;
  } case_entry_t;

  // classified cell passed from front to back
  typedef struct packed {
    logic signed [SampleBits-1:0] s_sw;
    logic signed [SampleBits-1:0] s_se;
    logic signed [SampleBits-1:0] s_nw;
    logic signed [SampleBits-1:0] s_ne;
    logic signed [SampleBits-1:0] lev;
    logic [IndexBits-1:0]         col;
    logic [IndexBits-1:0]         row;
    logic [2:0]                   len0;
    logic [2:0]                   len1;
    logic [5:0][2:0]              pts;
    logic                         rev;
  } cell_job_t;

  function automatic case_entry_t mk(input logic [2:0] l0, input logic [2:0] l1,
                                     input logic [2:0] p0, input logic [2:0] p1,
                                     input logic [2:0] p2, input logic [2:0] p3,
                                     input logic [2:0] p4, input logic [2:0] p5);
    case_entry_t e;
    e.len0 = l0;
    e.len1 = l1;
    e.pts  = {p5, p4, p3, p2, p1, p0};
    return e;
  endfunction

  function automatic case_entry_t quad_case(input logic [3:0] idx);
    case_entry_t e;
    e = mk(3'd0, 3'd0, PT_S, PT_S, PT_S, PT_S, PT_S, PT_S);
    case (idx)
      4'd1:  e = mk(3'd2, 3'd0, PT_S, PT_W, PT_S, PT_S, PT_S, PT_S);
      4'd2:  e = mk(3'd2, 3'd0, PT_E, PT_S, PT_S, PT_S, PT_S, PT_S);
      4'd3:  e = mk(3'd2, 3'd0, PT_E, PT_W, PT_S, PT_S, PT_S, PT_S);
      4'd4:  e = mk(3'd2, 3'd0, PT_N, PT_E, PT_S, PT_S, PT_S, PT_S);
      4'd5:  e = mk(3'd2, 3'd2, PT_N, PT_E, PT_S, PT_W, PT_S, PT_S);
      4'd6:  e = mk(3'd2, 3'd0, PT_N, PT_S, PT_S, PT_S, PT_S, PT_S);
      4'd7:  e = mk(3'd2, 3'd0, PT_N, PT_W, PT_S, PT_S, PT_S, PT_S);
      4'd8:  e = mk(3'd2, 3'd0, PT_W, PT_N, PT_S, PT_S, PT_S, PT_S);
      4'd9:  e = mk(3'd2, 3'd0, PT_S, PT_N, PT_S, PT_S, PT_S, PT_S);
      4'd10: e = mk(3'd2, 3'd2, PT_E, PT_S, PT_W, PT_N, PT_S, PT_S);
      4'd11: e = mk(3'd2, 3'd0, PT_E, PT_N, PT_S, PT_S, PT_S, PT_S);
      4'd12: e = mk(3'd2, 3'd0, PT_W, PT_E, PT_S, PT_S, PT_S, PT_S);
      4'd13: e = mk(3'd2, 3'd0, PT_S, PT_E, PT_S, PT_S, PT_S, PT_S);
      4'd14: e = mk(3'd2, 3'd0, PT_W, PT_S, PT_S, PT_S, PT_S, PT_S);
      default: e = mk(3'd0, 3'd0, PT_S, PT_S, PT_S, PT_S, PT_S, PT_S);
    endcase
    return e;
  endfunction

  function automatic case_entry_t tri_case(input logic [4:0] idx);
    case_entry_t e;
    e = mk(3'd0, 3'd0, PT_S, PT_S, PT_S, PT_S, PT_S, PT_S);
    case (idx)
      5'd1:  e = mk(3'd3, 3'd0, PT_S, PT_CSW, PT_W, PT_S, PT_S, PT_S);
      5'd2:  e = mk(3'd3, 3'd0, PT_E, PT_CSE, PT_S, PT_S, PT_S, PT_S);
      5'd3:  e = mk(3'd4, 3'd0, PT_E, PT_CSE, PT_CSW, PT_W, PT_S, PT_S);
      5'd4:  e = mk(3'd3, 3'd0, PT_N, PT_CNE, PT_E, PT_S, PT_S, PT_S);
      5'd5:  e = mk(3'd3, 3'd3, PT_N, PT_CNE, PT_E, PT_S, PT_CSW, PT_W);
      5'd6:  e = mk(3'd4, 3'd0, PT_N, PT_CNE, PT_CSE, PT_S, PT_S, PT_S);
      5'd7:  e = mk(3'd5, 3'd0, PT_N, PT_CNE, PT_CSE, PT_CSW, PT_W, PT_S);
      5'd8:  e = mk(3'd3, 3'd0, PT_W, PT_CNW, PT_N, PT_S, PT_S, PT_S);
      5'd9:  e = mk(3'd4, 3'd0, PT_S, PT_CSW, PT_CNW, PT_N, PT_S, PT_S);
      5'd10: e = mk(3'd3, 3'd3, PT_E, PT_CSE, PT_S, PT_W, PT_CNW, PT_N);
      5'd11: e = mk(3'd5, 3'd0, PT_E, PT_CSE, PT_CSW, PT_CNW, PT_N, PT_S);
      5'd12: e = mk(3'd4, 3'd0, PT_W, PT_CNW, PT_CNE, PT_E, PT_S, PT_S);
      5'd13: e = mk(3'd5, 3'd0, PT_S, PT_CSW, PT_CNW, PT_CNE, PT_E, PT_S);
      5'd14: e = mk(3'd5, 3'd0, PT_W, PT_CNW, PT_CNE, PT_CSE, PT_S, PT_S);
      5'd17: e = mk(3'd5, 3'd0, PT_S, PT_CSE, PT_CNE, PT_CNW, PT_W, PT_S);
      5'd18: e = mk(3'd5, 3'd0, PT_E, PT_CNE, PT_CNW, PT_CSW, PT_S, PT_S);
      5'd19: e = mk(3'd4, 3'd0, PT_E, PT_CNE, PT_CNW, PT_W, PT_S, PT_S);
      5'd20: e = mk(3'd5, 3'd0, PT_N, PT_CNW, PT_CSW, PT_CSE, PT_E, PT_S);
      5'd21: e = mk(3'd3, 3'd3, PT_N, PT_CNW, PT_W, PT_S, PT_CSE, PT_E);
      5'd22: e = mk(3'd4, 3'd0, PT_N, PT_CNW, PT_CSW, PT_S, PT_S, PT_S);
      5'd23: e = mk(3'd3, 3'd0, PT_N, PT_CNW, PT_W, PT_S, PT_S, PT_S);
      5'd24: e = mk(3'd5, 3'd0, PT_W, PT_CSW, PT_CSE, PT_CNE, PT_N, PT_S);
      5'd25: e = mk(3'd4, 3'd0, PT_S, PT_CSE, PT_CNE, PT_N, PT_S, PT_S);
      5'd26: e = mk(3'd3, 3'd3, PT_E, PT_CNE, PT_N, PT_W, PT_CSW, PT_S);
      5'd27: e = mk(3'd3, 3'd0, PT_E, PT_CNE, PT_N, PT_S, PT_S, PT_S);
      5'd28: e = mk(3'd4, 3'd0, PT_W, PT_CSW, PT_CSE, PT_E, PT_S, PT_S);
      5'd29: e = mk(3'd3, 3'd0, PT_S, PT_CSE, PT_E, PT_S, PT_S, PT_S);
      5'd30: e = mk(3'd3, 3'd0, PT_W, PT_CSW, PT_S, PT_S, PT_S, PT_S);
      default: e = mk(3'd0, 3'd0, PT_S, PT_S, PT_S, PT_S, PT_S, PT_S);
    endcase
    return e;
  endfunction

endpackage

### src/msq_front.sv
// Front end: accept cells, compute the case index, resolve saddles, register the job
module msq_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                triangle_mode,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [msq_pkg::SampleBits-1:0] corner_sw,
  input  logic signed [msq_pkg::SampleBits-1:0] corner_se,
  input  logic signed [msq_pkg::SampleBits-1:0] corner_nw,
  input  logic signed [msq_pkg::SampleBits-1:0] corner_ne,
  input  logic signed [msq_pkg::SampleBits-1:0] contour_level,
  input  logic [msq_pkg::IndexBits-1:0]       cell_col,
  input  logic [msq_pkg::IndexBits-1:0]       cell_row,
  input  logic                                cell_missing,
  output logic                                job_valid,
  input  logic                                job_stall,
  output msq_pkg::cell_job_t                  job
);
  import msq_pkg::*;

  localparam int SumBits = SampleBits + 3;

  logic [3:0]                idx4;
  logic [4:0]                idx5;
  logic signed [SumBits-1:0] sum4;
  logic signed [SumBits-1:0] lev4;
  logic signed [SumBits-1:0] d1;
  logic signed [SumBits-1:0] d2;
  logic [SumBits-1:0]        a1;
  logic [SumBits-1:0]        a2;
  case_entry_t               ent;
  logic                      rev;
  logic                      empty;
  logic                      take;
  cell_job_t                 job_next;

  // case index and diagonal distances
  always_comb begin
    idx4 = {corner_nw > contour_level, corner_ne > contour_level,
            corner_se > contour_level, corner_sw > contour_level};
    sum4 = SumBits'(corner_sw) + SumBits'(corner_se) + SumBits'(corner_nw)
         + SumBits'(corner_ne);
    lev4 = SumBits'(contour_level) <<< 2;
    idx5 = {sum4 > lev4, idx4};
    d1 = SumBits'(corner_sw) + SumBits'(corner_ne) - (SumBits'(contour_level) <<< 1);
    d2 = SumBits'(corner_se) + SumBits'(corner_nw) - (SumBits'(contour_level) <<< 1);
    a1 = d1[SumBits-1] ? SumBits'(-d1) : SumBits'(d1);
    a2 = d2[SumBits-1] ? SumBits'(-d2) : SumBits'(d2);
    rev = 1'b0;
    if (triangle_mode) begin
      ent = tri_case(idx5);
    end else begin
      if (idx4 == 4'd5 && a1 > a2) begin
        ent = quad_case(4'd10);
        rev = 1'b1;
      end else if (idx4 == 4'd10 && a1 < a2) begin
        ent = quad_case(4'd5);
        rev = 1'b1;
      end else begin
        ent = quad_case(idx4);
      end
    end
    empty = cell_missing || (ent.len0 == 3'd0);
    job_next.s_sw = corner_sw;
    job_next.s_se = corner_se;
    job_next.s_nw = corner_nw;
    job_next.s_ne = corner_ne;
    job_next.lev  = contour_level;
    job_next.col  = cell_col;
    job_next.row  = cell_row;
    job_next.len0 = ent.len0;
    job_next.len1 = ent.len1;
    job_next.pts  = ent.pts;
    job_next.rev  = rev;
  end

  assign in_stall = job_valid && job_stall;
  assign take     = in_valid && !in_stall;

  // hold the classified job until the queue takes it; drop empty cells
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!in_stall) begin
      job_valid <= take && !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job <= job_next;
    end
  end

endmodule

### src/msq_queue.sv
// Short job queue between front end and back end
module msq_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_stall,
  input  msq_pkg::cell_job_t wr_data,
  output logic               rd_valid,
  input  logic               rd_stall,
  output msq_pkg::cell_job_t rd_data
);
  import msq_pkg::*;

  cell_job_t               mem [QueueDepth];
  logic [QueuePtrBits-1:0] wptr;
  logic [QueuePtrBits-1:0] rptr;
  logic [QueuePtrBits:0]   count;
  logic                    push;
  logic                    pop;

  assign wr_stall = (count == (QueuePtrBits+1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;
  assign rd_data  = mem[rptr];

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (QueuePtrBits+1)'(push) - (QueuePtrBits+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

### src/msq_divider.sv
// Restoring divider: rounded fraction of num/den, one quotient bit per cycle
module msq_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [msq_pkg::DivBits-1:0]      num,
  input  logic [msq_pkg::DivBits-1:0]      den,
  input  logic                             half,
  output logic                             done,
  output logic [msq_pkg::FractionBits:0]   frac
);
  import msq_pkg::*;

  localparam int QBits   = FractionBits + 2;
  localparam int CntBits = $clog2(QBits + 1);
  localparam int RemBits = DivBits + 1;

  logic               busy;
  logic [RemBits-1:0] rem;
  logic [DivBits-1:0] dv;
  logic [QBits-1:0]   q;
  logic [CntBits-1:0] cnt;
  logic               hf;
  logic [RemBits-1:0] trial;
  logic [QBits-1:0]   rounded;
  logic [FractionBits:0] lim;

  // q = floor(num * 2^(F-sh+1) / den); result = (q + 1) >> 1
  assign trial   = {rem[RemBits-2:0], 1'b0};
  assign rounded = (q + QBits'(1)) >> 1;
  assign lim     = hf ? (FractionBits+1)'(1) << (FractionBits-1)
                      : (FractionBits+1)'(1) << FractionBits;
  assign frac    = (rounded > QBits'(lim)) ? lim : rounded[FractionBits:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one quotient bit per cycle, remainder starts at num (num < den)
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= RemBits'(num);
      dv  <= den;
      q   <= '0;
      hf  <= half;
      cnt <= half ? CntBits'(FractionBits) : CntBits'(FractionBits + 1);
    end else if (busy && cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (trial >= RemBits'(dv)) begin
        rem <= trial - RemBits'(dv);
        q   <= {q[QBits-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[QBits-2:0], 1'b0};
      end
    end
  end

endmodule

### src/msq_back.sv
// Back end: walk the point list of each job, interpolate each point, emit it
module msq_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  output logic                              job_stall,
  input  msq_pkg::cell_job_t                job,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [msq_pkg::PosBits-1:0]       point_x,
  output logic [msq_pkg::PosBits-1:0]       point_y,
  output logic                              segment_number,
  output logic                              segment_end,
  output logic                              item_end
);
  import msq_pkg::*;

  localparam int SB = SampleBits + 3;

  bk_state_t       state;
  bk_state_t       state_next;
  logic [2:0]      seg_pos;
  logic            seg;
  logic [2:0]      len;
  logic [2:0]      base;
  logic [2:0]      pidx;
  logic [2:0]      slot;
  pt_code_t        code;
  logic signed [SB-1:0] a;
  logic signed [SB-1:0] b;
  logic signed [SB-1:0] lv;
  logic signed [SB-1:0] nsig;
  logic signed [SB-1:0] dsig;
  logic signed [SB-1:0] sum;
  logic [DivBits-1:0]   n_abs;
  logic [DivBits-1:0]   d_abs;
  logic                 centre;
  logic                 sat_zero;
  logic                 sat_one;
  logic                 dstart;
  logic                 ddone;
  logic [FractionBits:0] dfrac;
  logic [FractionBits:0] t;
  logic                  last_seg;
  logic                  last_pt;
  logic [PosBits-1:0]    x0;
  logic [PosBits-1:0]    y0;
  logic [PosBits-1:0]    one;
  logic [PosBits-1:0]    tx;
  logic                  emit;
  logic                  obuf_free;

  // point code of the current position
  always_comb begin
    len  = seg ? job.len1 : job.len0;
    base = seg ? job.len0 : 3'd0;
    pidx = job.rev ? (len - 3'd1 - seg_pos) : seg_pos;
    slot = base + pidx;
    code = pt_code_t'(job.pts[slot]);
    sum  = SB'(job.s_sw) + SB'(job.s_se) + SB'(job.s_nw) + SB'(job.s_ne);
    lv   = SB'(job.lev);
    centre = 1'b0;
    case (code)
      PT_S:   begin a = SB'(job.s_sw); b = SB'(job.s_se); end
      PT_N:   begin a = SB'(job.s_nw); b = SB'(job.s_ne); end
      PT_W:   begin a = SB'(job.s_sw); b = SB'(job.s_nw); end
      PT_E:   begin a = SB'(job.s_se); b = SB'(job.s_ne); end
      PT_CSW: begin a = SB'(job.s_sw); b = sum; centre = 1'b1; end
      PT_CSE: begin a = SB'(job.s_se); b = sum; centre = 1'b1; end
      PT_CNW: begin a = SB'(job.s_nw); b = sum; centre = 1'b1; end
      default: begin a = SB'(job.s_ne); b = sum; centre = 1'b1; end
    endcase
    if (centre) begin
      nsig = (lv <<< 2) - (a <<< 2);
      dsig = b - (a <<< 2);
    end else begin
      nsig = lv - a;
      dsig = b - a;
    end
    if (dsig[SB-1]) begin
      nsig = -nsig;
      dsig = -dsig;
    end
    n_abs    = DivBits'(nsig);
    d_abs    = DivBits'(dsig);
    sat_zero = (dsig == '0) || nsig[SB-1] || (nsig == '0);
    sat_one  = !sat_zero && (nsig >= dsig);
  end

  assign last_seg = seg ? 1'b1 : (job.len1 == 3'd0);
  assign last_pt  = last_seg && (seg_pos == len - 3'd1);
  assign obuf_free = !out_valid || !out_stall;

  always_comb begin
    t = dfrac;
    if (sat_zero) t = '0;
    else if (sat_one) t = centre ? (FractionBits+1)'(1) << (FractionBits-1)
                                 : (FractionBits+1)'(1) << FractionBits;
  end

  msq_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (n_abs),
    .den   (d_abs),
    .half  (centre),
    .done  (ddone),
    .frac  (dfrac)
  );

  // sequencer: start a divide unless the offset saturates, wait, emit into output register
  always_comb begin
    state_next = state;
    dstart     = 1'b0;
    emit       = 1'b0;
    job_stall  = 1'b1;
    case (state)
      BK_IDLE: begin
        if (job_valid) begin
          if (sat_zero || sat_one) begin
            state_next = BK_OUT;
          end else begin
            dstart     = 1'b1;
            state_next = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        if (ddone) state_next = BK_OUT;
      end
      BK_OUT: begin
        if (obuf_free) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
          job_stall  = !last_pt;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      seg     <= 1'b0;
      seg_pos <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        if (last_pt) begin
          seg <= 1'b0; seg_pos <= '0;
        end else if (seg_pos == len - 3'd1) begin
          seg <= 1'b1; seg_pos <= '0;
        end else begin
          seg_pos <= seg_pos + 3'd1;
        end
      end
    end
  end

  // position from code and offset
  assign x0  = PosBits'(job.col) << FractionBits;
  assign y0  = PosBits'(job.row) << FractionBits;
  assign one = PosBits'(1) << FractionBits;
  assign tx  = PosBits'(t);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      segment_number <= seg;
      segment_end    <= (seg_pos == len - 3'd1);
      item_end       <= last_pt;
      case (code)
        PT_S:   begin point_x <= x0 + tx;       point_y <= y0;            end
        PT_N:   begin point_x <= x0 + tx;       point_y <= y0 + one;      end
        PT_W:   begin point_x <= x0;            point_y <= y0 + tx;       end
        PT_E:   begin point_x <= x0 + one;      point_y <= y0 + tx;       end
        PT_CSW: begin point_x <= x0 + tx;       point_y <= y0 + tx;       end
        PT_CSE: begin point_x <= x0 + one - tx; point_y <= y0 + tx;       end
        PT_CNW: begin point_x <= x0 + tx;       point_y <= y0 + one - tx; end
        default: begin point_x <= x0 + one - tx; point_y <= y0 + one - tx; end
      endcase
    end
  end

endmodule

### src/marching_squares_cell_emitter.sv
// Top level of the marching squares cell emitter
// Usage:
//   Input channel (in_valid / in_stall) takes one grid cell per request;
//   output channel (out_valid / out_stall) gives one contour point per
//   request, with its piece number and end-of-piece / end-of-cell marks.
//   Missing cells and cells with no crossing give no points. The user writes
//   triangle_mode (cfg_we / cfg_data) only while the block is idle; unchecked.
// Timing:
//   The front end classifies a cell and registers the job, then places it in a
//   four-entry job queue, taking a request every cycle until that is full.
//   The back end produces each point in turn: a saturated offset goes from
//   the sequencer straight to the output register, while an interpolated
//   one, on a cell edge or a centre line, first waits for the one-bit-per-cycle
//   divider. A cell gives 0 to 6 points. After acceptance a cell passes the
//   front-end job register and the job queue before the back end emits its
//   first point.
// Reset clears the queue, sequencer and triangle_mode. When the receiver
// stalls, the output register holds its point, the back end waits, and the
// queue fills before in_stall rises.
module marching_squares_cell_emitter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [msq_pkg::SampleBits-1:0] corner_sw,
  input  logic signed [msq_pkg::SampleBits-1:0] corner_se,
  input  logic signed [msq_pkg::SampleBits-1:0] corner_nw,
  input  logic signed [msq_pkg::SampleBits-1:0] corner_ne,
  input  logic signed [msq_pkg::SampleBits-1:0] contour_level,
  input  logic [msq_pkg::IndexBits-1:0]       cell_col,
  input  logic [msq_pkg::IndexBits-1:0]       cell_row,
  input  logic                                cell_missing,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [msq_pkg::PosBits-1:0]         point_x,
  output logic [msq_pkg::PosBits-1:0]         point_y,
  output logic                                segment_number,
  output logic                                segment_end,
  output logic                                item_end
);
  import msq_pkg::*;

  logic      triangle_mode;
  logic      f_valid;
  logic      f_stall;
  cell_job_t f_job;
  logic      q_valid;
  logic      q_stall;
  cell_job_t q_job;

  // hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      triangle_mode <= 1'b0;
    end else if (cfg_we) begin
      triangle_mode <= cfg_data;
    end
  end

  msq_front u_front (
    .clk (clk), .rst (rst), .triangle_mode (triangle_mode),
    .in_valid (in_valid), .in_stall (in_stall),
    .corner_sw (corner_sw), .corner_se (corner_se),
    .corner_nw (corner_nw), .corner_ne (corner_ne),
    .contour_level (contour_level), .cell_col (cell_col),
    .cell_row (cell_row), .cell_missing (cell_missing),
    .job_valid (f_valid), .job_stall (f_stall), .job (f_job)
  );

  msq_queue u_queue (
    .clk (clk), .rst (rst),
    .wr_valid (f_valid), .wr_stall (f_stall), .wr_data (f_job),
    .rd_valid (q_valid), .rd_stall (q_stall), .rd_data (q_job)
  );

  msq_back u_back (
    .clk (clk), .rst (rst),
    .job_valid (q_valid), .job_stall (q_stall), .job (q_job),
    .out_valid (out_valid), .out_stall (out_stall),
    .point_x (point_x), .point_y (point_y),
    .segment_number (segment_number), .segment_end (segment_end),
    .item_end (item_end)
  );

endmodule

### src/msq_checker.sv
// Port-level checker for the marching squares cell emitter, with its bind
module msq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [msq_pkg::PosBits-1:0]   point_x,
  input logic                          segment_number,
  input logic                          segment_end,
  input logic                          item_end
);
  import msq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x))
    else $error("stalled point changed");

  a_item_end_seg: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_end |-> segment_end)
    else $error("cell end without piece end");

  a_seg1_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && segment_end && !item_end |=> !out_valid || segment_number)
    else $error("second piece not marked");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind marching_squares_cell_emitter msq_checker u_msq_checker (
  .clk (clk), .rst (rst), .out_valid (out_valid), .out_stall (out_stall),
  .point_x (point_x), .segment_number (segment_number),
  .segment_end (segment_end), .item_end (item_end)
);
